// ----- design/rac_pkg.sv -----
// ----------------------------------------------------------------------------
// rac_pkg
// Shared types, constants and helpers of the row alpha compositor.
// ----------------------------------------------------------------------------
package rac_pkg;

  // Row geometry
  localparam int ROW_WIDTH = 4096;
  localparam int ADDR_W    = (ROW_WIDTH > 1) ? $clog2(ROW_WIDTH) : 1;
  localparam int X_W       = 12;

  // Samples
  localparam int SAMPLE_W  = 16;
  localparam int PIX_W     = 4 * SAMPLE_W;
  localparam int PROD_W    = 2 * SAMPLE_W;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 16'hFFFF;

  // Store word: valid flag over four samples
  localparam int WORD_W    = PIX_W + 1;

  // Pixel type codes
  localparam logic [1:0] PT_RGB  = 2'd0;
  localparam logic [1:0] PT_RGBA = 2'd1;
  localparam logic [1:0] PT_CMYK = 2'd2;

  // Request kinds (tuser)
  localparam logic KIND_COMPOSE = 1'b0;
  localparam logic KIND_READ    = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_MUL,
    ST_SUM
  } rac_state_t;

  // Stage enables for the blend lanes
  typedef struct packed {
    logic mul_en;
    logic sum_en;
  } rac_lane_ctl_t;

  // Fold type three onto CMYK
  function automatic logic [1:0] fold_type(input logic [1:0] pt);
    logic [1:0] f;
    f = (pt == PT_RGB) ? PT_RGB : ((pt == PT_RGBA) ? PT_RGBA : PT_CMYK);
    return f;
  endfunction

  // Floor division by 2^16-1 of a value no larger than (2^16-1)^2:
  // q0 = n >> 16 leaves a remainder of n[15:0] + q0, one correction step.
  function automatic logic [SAMPLE_W-1:0] div_max(input logic [PROD_W-1:0] n);
    logic [SAMPLE_W-1:0] q0;
    logic [SAMPLE_W:0]   rem;
    logic [SAMPLE_W-1:0] q;
    q0  = n[PROD_W-1:SAMPLE_W];
    rem = {1'b0, n[SAMPLE_W-1:0]} + {1'b0, q0};
    q   = (rem >= {1'b0, SAMPLE_MAX}) ? q0 + 1'b1 : q0;
    return q;
  endfunction

endpackage

// ----- design/rac_row_mem.sv -----
// ----------------------------------------------------------------------------
// rac_row_mem
// Single-port-write, single-port-read row store with registered read data.
// ----------------------------------------------------------------------------
module rac_row_mem (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [rac_pkg::ADDR_W-1:0] wr_addr,
  input  logic [rac_pkg::WORD_W-1:0] wr_data,
  input  logic                       rd_en,
  input  logic [rac_pkg::ADDR_W-1:0] rd_addr,
  output logic [rac_pkg::WORD_W-1:0] rd_data
);

  logic [rac_pkg::WORD_W-1:0] row_mem_r [rac_pkg::ROW_WIDTH];
  logic [rac_pkg::WORD_W-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      row_mem_r[wr_addr] <= wr_data;
    end
  end

  // Read port, registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= row_mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- design/rac_blend_lane.sv -----
// ----------------------------------------------------------------------------
// rac_blend_lane
// One sample lane of the over blend: (dst*(max-a) + src*a) / max.
// ----------------------------------------------------------------------------
module rac_blend_lane (
  input  logic                         clk,
  input  rac_pkg::rac_lane_ctl_t       ctl,
  input  logic [rac_pkg::SAMPLE_W-1:0] dst,
  input  logic [rac_pkg::SAMPLE_W-1:0] src,
  input  logic [rac_pkg::SAMPLE_W-1:0] alpha,
  output logic [rac_pkg::SAMPLE_W-1:0] blend
);

  logic [rac_pkg::SAMPLE_W-1:0] inv_alpha;
  logic [rac_pkg::PROD_W-1:0]   prod_d_r;
  logic [rac_pkg::PROD_W-1:0]   prod_s_r;
  logic [rac_pkg::PROD_W-1:0]   sum_r;

  assign inv_alpha = rac_pkg::SAMPLE_MAX - alpha;

  // Products
  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_d_r <= dst * inv_alpha;
      prod_s_r <= src * alpha;
    end
  end

  // Sum, cannot exceed max*max
  always_ff @(posedge clk) begin
    if (ctl.sum_en) begin
      sum_r <= prod_d_r + prod_s_r;
    end
  end

  assign blend = rac_pkg::div_max(sum_r);

endmodule

// ----- design/row_alpha_compositor_core.sv -----
// ----------------------------------------------------------------------------
// row_alpha_compositor_core
// One-row compositor: blends source pixels over a stored row, reads and clears.
// ----------------------------------------------------------------------------
// The row lives in one synchronous memory of ROW_WIDTH words, each a valid
// flag and four 16-bit samples. After reset the block sweeps the memory once,
// one entry a cycle, with in_tready low; cfg writes are taken throughout.
// Requests are handled one at a time: a read goes through accept, then memory
// lookup and result; a compose goes through accept, lookup with the multiply,
// sum, then divide with write-back, following the registered memory read and
// the two registered stages of the blend lanes. A result waits in an output
// register, so a new request is accepted while it does; a read request stalls
// in lookup only while that register is still full.
// pixel_type must be written only while no request is in flight.
module row_alpha_compositor_core (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_wr_data,   // pixel_type
  // Request channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,      // x_pos, sample_0..sample_3, src_alpha,
                                     // src_has_alpha, zero pad
  input  logic        in_tuser,      // kind
  // Result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata      // out_0, out_1, out_2, out_3
);

  localparam int SW = rac_pkg::SAMPLE_W;
  localparam int AW = rac_pkg::ADDR_W;

  // Request field offsets in tdata
  localparam int OFF_SMP   = rac_pkg::X_W;
  localparam int OFF_ALPHA = OFF_SMP + 4 * SW;
  localparam int OFF_HASA  = OFF_ALPHA + SW;

  rac_pkg::rac_state_t     state_r, state_nxt;
  logic [AW-1:0]           clr_cnt_r, clr_cnt_nxt;
  logic [1:0]              pt_r;
  logic [1:0]              fmt;

  logic                    kind_r;
  logic [rac_pkg::X_W-1:0] x_r;
  logic [SW-1:0]           smp_r [4];
  logic [SW-1:0]           alpha_r;
  logic                    with_alpha_r;

  logic [SW-1:0]           px_r [4];
  logic [SW-1:0]           look_px [4];
  logic [SW-1:0]           bg_px [4];
  logic [SW-1:0]           blend_q [4];
  logic [SW-1:0]           new_px [4];

  logic                    out_valid_r;
  logic [63:0]             out_data_r;

  logic                    in_accept;
  logic                    in_range;
  logic                    look_hit;
  logic                    out_load;
  logic                    px_load;
  rac_pkg::rac_lane_ctl_t  lane_ctl;

  logic                          mem_we;
  logic [AW-1:0]                 mem_waddr;
  logic [rac_pkg::WORD_W-1:0]    mem_wdata;
  logic [rac_pkg::WORD_W-1:0]    mem_rdata;

  assign in_tready = (state_r == rac_pkg::ST_IDLE);
  assign in_accept = in_tvalid && in_tready;
  assign fmt       = rac_pkg::fold_type(pt_r);
  assign in_range  = ({1'b0, x_r} < (rac_pkg::X_W + 1)'(rac_pkg::ROW_WIDTH))
                     || (rac_pkg::ROW_WIDTH >= (1 << rac_pkg::X_W));

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pt_r <= rac_pkg::PT_RGB;
    end else if (cfg_wr_en) begin
      pt_r <= cfg_wr_data;
    end
  end

  // Request capture
  always_ff @(posedge clk) begin
    if (in_accept) begin
      kind_r      <= in_tuser;
      x_r         <= in_tdata[rac_pkg::X_W-1:0];
      for (int i = 0; i < 4; i++) begin
        smp_r[i] <= in_tdata[OFF_SMP + i*SW +: SW];
      end
      alpha_r      <= in_tdata[OFF_ALPHA +: SW];
      with_alpha_r <= in_tdata[OFF_HASA];
    end
  end

  // Row store, read issued with the accepted request
  rac_row_mem u_row_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (in_accept),
    .rd_addr (in_tdata[AW-1:0]),
    .rd_data (mem_rdata)
  );

  // Background pixel of the current type
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      bg_px[i] = (fmt == rac_pkg::PT_CMYK) ? '0 : rac_pkg::SAMPLE_MAX;
    end
    bg_px[3] = (fmt == rac_pkg::PT_RGBA) ? rac_pkg::SAMPLE_MAX : '0;
  end

  // Looked-up pixel: stored or background
  assign look_hit = in_range && mem_rdata[rac_pkg::PIX_W];
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      look_px[i] = look_hit ? mem_rdata[i*SW +: SW] : bg_px[i];
    end
  end

  // Blend lanes
  for (genvar g = 0; g < 4; g++) begin : g_lane
    rac_blend_lane u_lane (
      .clk   (clk),
      .ctl   (lane_ctl),
      .dst   (look_px[g]),
      .src   (smp_r[g]),
      .alpha (alpha_r),
      .blend (blend_q[g])
    );
  end

  // Hold the looked-up pixel for copy and alpha clamp
  always_ff @(posedge clk) begin
    if (px_load) begin
      for (int i = 0; i < 4; i++) begin
        px_r[i] <= look_px[i];
      end
    end
  end

  // Composed pixel
  always_comb begin
    logic [SW-1:0] inv_a;
    inv_a = rac_pkg::SAMPLE_MAX - alpha_r;
    for (int i = 0; i < 3; i++) begin
      new_px[i] = with_alpha_r ? blend_q[i] : smp_r[i];
    end
    if (with_alpha_r) begin
      if (fmt == rac_pkg::PT_RGBA) begin
        new_px[3] = ((alpha_r != '0) && (px_r[3] > inv_a)) ? inv_a : px_r[3];
      end else if (fmt == rac_pkg::PT_CMYK) begin
        new_px[3] = blend_q[3];
      end else begin
        new_px[3] = px_r[3];
      end
    end else begin
      if (fmt == rac_pkg::PT_RGBA) begin
        new_px[3] = rac_pkg::SAMPLE_MAX;
      end else if (fmt == rac_pkg::PT_CMYK) begin
        new_px[3] = smp_r[3];
      end else begin
        new_px[3] = px_r[3];
      end
    end
    if (fmt == rac_pkg::PT_RGB) begin
      new_px[3] = '0;
    end
  end

  // Sequencer: next state and controls
  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    mem_we      = 1'b0;
    mem_waddr   = x_r[AW-1:0];
    mem_wdata   = '0;
    lane_ctl    = '0;
    out_load    = 1'b0;
    px_load     = 1'b0;
    case (state_r)
      rac_pkg::ST_CLEAR: begin
        mem_we      = 1'b1;
        mem_waddr   = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == AW'(rac_pkg::ROW_WIDTH - 1)) begin
          state_nxt = rac_pkg::ST_IDLE;
        end
      end
      rac_pkg::ST_IDLE: begin
        if (in_accept) begin
          state_nxt = rac_pkg::ST_LOOK;
        end
      end
      rac_pkg::ST_LOOK: begin
        if (kind_r == rac_pkg::KIND_READ) begin
          if (!out_valid_r || out_tready) begin
            out_load  = 1'b1;
            mem_we    = in_range;  // clear valid flag
            state_nxt = rac_pkg::ST_IDLE;
          end
        end else if (!in_range) begin
          state_nxt = rac_pkg::ST_IDLE;
        end else begin
          lane_ctl.mul_en = 1'b1;
          px_load         = 1'b1;
          state_nxt       = rac_pkg::ST_MUL;
        end
      end
      rac_pkg::ST_MUL: begin
        lane_ctl.sum_en = 1'b1;
        state_nxt       = rac_pkg::ST_SUM;
      end
      rac_pkg::ST_SUM: begin
        mem_we    = 1'b1;
        mem_wdata = {1'b1, new_px[3], new_px[2], new_px[1], new_px[0]};
        state_nxt = rac_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = rac_pkg::ST_IDLE;
      end
    endcase
  end

  // Sequencer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= rac_pkg::ST_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= {(fmt == rac_pkg::PT_RGB) ? {SW{1'b0}} : look_px[3],
                     look_px[2], look_px[1], look_px[0]};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ----- design/rac_checker.sv -----
// ----------------------------------------------------------------------------
// rac_checker
// Port-level checks of the row alpha compositor, bound to the top level.
// ----------------------------------------------------------------------------
module rac_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata
);

  // Stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // Stalled result keeps its data
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result data changed while stalled");

  // One request at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request accepted while previous one in flight");

  // Compose produces no result
  a_compose_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tuser && !out_tvalid |=> !out_tvalid)
    else $error("result appeared for a compose request");

  // Read with free output gives its result from lookup via the output register
  a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser && !out_tvalid |-> ##2 out_tvalid)
    else $error("read result missing");

endmodule

bind row_alpha_compositor_core rac_checker u_rac_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
